### hw/rtl/wpf_pkg.sv
package wpf_pkg;

   // default stack depth
   localparam int PATH_DEPTH_DEF = 16;

   // request codes
   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_PUSH = 2'd1;
   localparam logic [1:0] REQ_SET  = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // register indexes
   localparam logic CSR_STEP = 1'b0;
   localparam logic CSR_TURN = 1'b1;

   // reset values
   localparam logic [15:0] STEP_RESET = 16'd3277;
   localparam logic [15:0] TURN_RESET = 16'd66;
   localparam logic signed [15:0] HEAD_UNIT = 16'sd16384;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
   } wpf_req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic [4:0]         points_left;
      logic [1:0]         status;
   } wpf_rsp_type;

   // handshake of a multi-cycle arithmetic unit
   typedef struct packed {
      logic start;
   } wpf_unit_ctl_type;

endpackage

### hw/rtl/wpf_ram.sv
module wpf_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/wpf_sqrt.sv
module wpf_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  wpf_pkg::wpf_unit_ctl_type ctl,
   input  logic [62:0]               radicand,
   output logic                      done,
   output logic [31:0]               root
);
   import wpf_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] n_ff, n_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [35:0] rem_sh;
   logic [35:0] trial;

   // one result bit per cycle, two radicand bits consumed
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_sh  = {rem_ff, n_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         n_in    = {1'b0, radicand};
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         n_in = {n_ff[61:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = 34'(rem_sh - trial);
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh[33:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### hw/rtl/wpf_div.sv
module wpf_div (
   input  logic                      clock,
   input  logic                      reset,
   input  wpf_pkg::wpf_unit_ctl_type ctl,
   input  logic [47:0]               dividend,
   input  logic [31:0]               divisor,
   output logic                      done,
   output logic [15:0]               quotient
);
   import wpf_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [15:0] low_ff, low_in;
   logic [15:0] q_ff, q_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] trial;
   logic        ge;

   // restoring division, one quotient bit per cycle; quotient fits 16 bits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, low_ff[15]};
      ge      = trial >= {1'b0, dvs_ff};
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend[47:16];
         low_in  = dividend[15:0];
         q_in    = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? 32'(trial - {1'b0, dvs_ff}) : trial[31:0];
         q_in   = {q_ff[14:0], ge};
         low_in = {low_ff[14:0], 1'b0};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

### hw/rtl/waypoint_path_follower.sv
// Push, set-position, unused requests: result strobed in the cycle after start.
// Tick: a waypoint reached takes a pass through the square root unit, a partial
// advance a square root and two divisions, and the turn test a square root, plus
// two divisions when the heading is updated; the tick then strobes its result.
// One item at a time; busy stays high until the tick's result is strobed.
// Synchronous reset: position 0, heading unit x, empty stack, default registers.
module waypoint_path_follower #(
   parameter int PATH_DEPTH = wpf_pkg::PATH_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  wpf_pkg::wpf_req_type req_data,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [15:0]          csr_wdata,
   output logic                 rsp_valid,
   output wpf_pkg::wpf_rsp_type rsp_data
);
   import wpf_pkg::*;

   localparam int CW = $clog2(PATH_DEPTH + 1);
   localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;

   typedef enum logic [4:0] {
      S_IDLE, S_FETCH, S_LOAD, S_TURN, S_MUL_A, S_MUL_B, S_MUL_C,
      S_SQ_GO, S_SQ_WAIT, S_DECIDE, S_MUL_X, S_DX_GO, S_DX_WAIT,
      S_MUL_Y, S_DY_GO, S_DY_WAIT, S_APPLY, S_DONE
   } state_type;

   typedef struct packed {
      logic        halved;
      logic        neg_x;
      logic        neg_y;
      logic [30:0] ax;
      logic [30:0] ay;
   } vec_type;

   state_type          state_ff, state_in;
   logic signed [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [15:0] head_x_ff, head_x_in, head_y_ff, head_y_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [15:0]        step_ff, step_in, turn_ff, turn_in;
   logic signed [31:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [31:0] wx_ff, wx_in, wy_ff, wy_in;
   logic [15:0]        budget_ff, budget_in;
   vec_type            vec_ff, vec_in;
   logic               turn_mode_ff, turn_mode_in;
   logic [61:0]        prod_ff, prod_in;
   logic [62:0]        sq_ff, sq_in;
   logic [15:0]        qx_ff, qx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   wpf_rsp_type        rsp_ff, rsp_in;

   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [63:0]        ram_rdata;
   wpf_unit_ctl_type   sq_ctl, div_ctl;
   logic               sq_done, div_done;
   logic [31:0]        len;
   logic [15:0]        div_q;
   logic [30:0]        mul_a, mul_b;
   logic               fin;
   logic [1:0]         status;
   logic [CW+4:0]      count_ext;
   logic [15:0]        thr;
   logic [31:0]        dq_x, dq_y;
   logic [CW-1:0]      top_idx;

   // difference vector, magnitudes halved when either is too large
   function automatic vec_type make_vec(input logic signed [31:0] ex, input logic signed [31:0] ey,
                                        input logic signed [31:0] bx, input logic signed [31:0] by);
      logic [32:0] dx, dy, mx, my;
      vec_type     v;
      dx       = {ex[31], ex} - {bx[31], bx};
      dy       = {ey[31], ey} - {by[31], by};
      mx       = dx[32] ? 33'(-dx) : dx;
      my       = dy[32] ? 33'(-dy) : dy;
      v.neg_x  = dx[32];
      v.neg_y  = dy[32];
      v.halved = (|mx[32:31]) || (|my[32:31]);
      v.ax     = v.halved ? mx[31:1] : mx[30:0];
      v.ay     = v.halved ? my[31:1] : my[30:0];
      return v;
   endfunction

   // waypoint stack
   wpf_ram #(.WIDTH(64), .DEPTH(PATH_DEPTH), .ADDR_W(AW)) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ({req_data.coord_x, req_data.coord_y}),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   wpf_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sq_ctl),
      .radicand (sq_ff),
      .done     (sq_done),
      .root     (len)
   );

   wpf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (prod_ff[47:0]),
      .divisor  (len),
      .done     (div_done),
      .quotient (div_q)
   );

   assign top_idx   = count_ff - CW'(1);
   assign ram_raddr = top_idx[AW-1:0];
   assign ram_waddr = count_ff[AW-1:0];
   assign thr       = turn_mode_ff ? turn_ff : budget_ff;
   assign dq_x      = {16'd0, qx_ff};
   assign dq_y      = {16'd0, div_q};

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      head_x_in    = head_x_ff;
      head_y_in    = head_y_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      turn_in      = turn_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      budget_in    = budget_ff;
      vec_in       = vec_ff;
      turn_mode_in = turn_mode_ff;
      prod_in      = prod_ff;
      sq_in        = sq_ff;
      qx_in        = qx_ff;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      sq_ctl.start = 1'b0;
      div_ctl.start = 1'b0;
      fin          = 1'b0;
      status       = STATUS_OK;
      mul_a        = vec_ff.ax;
      mul_b        = vec_ff.ax;

      // register writes
      if (csr_we) begin
         if (csr_index == CSR_STEP) begin
            step_in = csr_wdata;
         end else begin
            turn_in = csr_wdata;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_data.req_type)
                  REQ_TICK: begin
                     if (count_ff == '0) begin
                        status = STATUS_EMPTY;
                        fin    = 1'b1;
                     end else begin
                        sx_in        = pos_x_ff;
                        sy_in        = pos_y_ff;
                        budget_in    = step_ff;
                        turn_mode_in = 1'b0;
                        state_in     = S_FETCH;
                     end
                  end
                  REQ_PUSH: begin
                     if (count_ff == CW'(PATH_DEPTH)) begin
                        status = STATUS_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                     fin = 1'b1;
                  end
                  REQ_SET: begin
                     pos_x_in = req_data.coord_x;
                     pos_y_in = req_data.coord_y;
                     fin      = 1'b1;
                  end
                  default: fin = 1'b1;
               endcase
            end
         end
         S_FETCH: begin
            if (count_ff == '0 || budget_ff == '0) begin
               state_in = S_TURN;
            end else begin
               ram_re   = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            wx_in    = ram_rdata[63:32];
            wy_in    = ram_rdata[31:0];
            vec_in   = make_vec(ram_rdata[63:32], ram_rdata[31:0], pos_x_ff, pos_y_ff);
            state_in = S_MUL_A;
         end
         S_TURN: begin
            turn_mode_in = 1'b1;
            vec_in       = make_vec(pos_x_ff, pos_y_ff, sx_ff, sy_ff);
            state_in     = S_MUL_A;
         end
         // squared length through the shared multiplier
         S_MUL_A: begin
            prod_in  = mul_a * mul_b;
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            mul_a    = vec_ff.ay;
            mul_b    = vec_ff.ay;
            sq_in    = {1'b0, prod_ff};
            prod_in  = mul_a * mul_b;
            state_in = S_MUL_C;
         end
         S_MUL_C: begin
            mul_a    = {15'd0, thr};
            mul_b    = {15'd0, thr};
            sq_in    = sq_ff + {1'b0, prod_ff};
            prod_in  = mul_a * mul_b;
            state_in = S_SQ_GO;
         end
         S_SQ_GO: begin
            sq_ctl.start = 1'b1;
            state_in     = S_SQ_WAIT;
         end
         S_SQ_WAIT: begin
            if (sq_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!turn_mode_ff) begin
               if (!vec_ff.halved && sq_ff <= {1'b0, prod_ff}) begin
                  // waypoint reached: snap and pop
                  pos_x_in  = wx_ff;
                  pos_y_in  = wy_ff;
                  count_in  = count_ff - CW'(1);
                  budget_in = budget_ff - len[15:0];
                  state_in  = S_FETCH;
               end else begin
                  state_in = S_MUL_X;
               end
            end else if (vec_ff.halved || sq_ff > {1'b0, prod_ff}) begin
               state_in = S_MUL_X;
            end else begin
               state_in = S_DONE;
            end
         end
         // component scale: |d| * factor / len
         S_MUL_X: begin
            mul_b    = turn_mode_ff ? 31'(HEAD_UNIT) : {15'd0, budget_ff};
            prod_in  = mul_a * mul_b;
            state_in = S_DX_GO;
         end
         S_DX_GO: begin
            div_ctl.start = 1'b1;
            state_in      = S_DX_WAIT;
         end
         S_DX_WAIT: begin
            if (div_done) begin
               qx_in    = div_q;
               state_in = S_MUL_Y;
            end
         end
         S_MUL_Y: begin
            mul_a    = vec_ff.ay;
            mul_b    = turn_mode_ff ? 31'(HEAD_UNIT) : {15'd0, budget_ff};
            prod_in  = mul_a * mul_b;
            state_in = S_DY_GO;
         end
         S_DY_GO: begin
            div_ctl.start = 1'b1;
            state_in      = S_DY_WAIT;
         end
         S_DY_WAIT: begin
            if (div_done) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (!turn_mode_ff) begin
               pos_x_in  = pos_x_ff + (vec_ff.neg_x ? 32'(-dq_x) : dq_x);
               pos_y_in  = pos_y_ff + (vec_ff.neg_y ? 32'(-dq_y) : dq_y);
               budget_in = '0;
               state_in  = S_FETCH;
            end else begin
               head_x_in = vec_ff.neg_x ? 16'(-qx_ff) : qx_ff;
               head_y_in = vec_ff.neg_y ? 16'(-div_q) : div_q;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            fin      = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // result item from the updated state
      count_ext    = {5'd0, count_in};
      rsp_valid_in = fin;
      if (fin) begin
         rsp_in.pos_x       = pos_x_in;
         rsp_in.pos_y       = pos_y_in;
         rsp_in.dir_x       = head_x_in;
         rsp_in.dir_y       = head_y_in;
         rsp_in.points_left = count_ext[4:0];
         rsp_in.status      = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         head_x_ff    <= HEAD_UNIT;
         head_y_ff    <= '0;
         count_ff     <= '0;
         step_ff      <= STEP_RESET;
         turn_ff      <= TURN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         head_x_ff    <= head_x_in;
         head_y_ff    <= head_y_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         turn_ff      <= turn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      wx_ff        <= wx_in;
      wy_ff        <= wy_in;
      budget_ff    <= budget_in;
      vec_ff       <= vec_in;
      turn_mode_ff <= turn_mode_in;
      prod_ff      <= prod_in;
      sq_ff        <= sq_in;
      qx_ff        <= qx_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // an accepted item is either answered next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid || busy)
      else $error("accepted item neither answered nor in progress");

   // stack count never exceeds the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(PATH_DEPTH))
      else $error("stack count out of range");

   // a reached waypoint never costs more than the remaining budget
   a_budget_cost: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DECIDE && !turn_mode_ff && !vec_ff.halved &&
      sq_ff <= {1'b0, prod_ff} |-> len[31:16] == 16'd0 && len[15:0] <= budget_ff)
      else $error("waypoint cost exceeds budget");

   // heading stays a unit vector component
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.dir_x >= -HEAD_UNIT && rsp_data.dir_x <= HEAD_UNIT &&
                    rsp_data.dir_y >= -HEAD_UNIT && rsp_data.dir_y <= HEAD_UNIT)
      else $error("heading component out of range");

endmodule
